// ===== rtl/core/rmth_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running median package
// Shared widths and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned MedianW = 17;
  localparam int unsigned CountW  = 11;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_START,
    OP_PUSH_STEP,
    OP_POP_START,
    OP_POP_STEP,
    OP_MEDIAN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   heap_sel;   // 0: lower (max) heap, 1: upper (min) heap
    logic   src_top;    // push the top of the other heap instead of the sample
    logic   med_two;    // median is twice the top of the selected heap
  } dp_cmd_t;

  typedef struct packed {
    logic busy;         // push or pop still walking the tree
    logic lower_empty;
    logic v2_eq;
    logic v2_lt;
    logic lower_le;     // lower_count <= upper_count
    logic same;         // lower_count == upper_count
    logic lower_full;
    logic upper_full;
  } dp_status_t;

endpackage : rmth_pkg
`default_nettype wire

// ===== rtl/core/running_median_two_heaps_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running median, two heaps
// Max-heap of the lower half and min-heap of the upper half; reports twice
// the running median, a refusal flag and the sample count after each item.
//
//   channel | signals                              | direction
//   in      | in_valid_i, in_stall_o, value_i      | into block
//   out     | out_valid_o, out_stall_i, median_... | out of block
//
// A plain push sift-up walks one level at a time, a read then a compare. A
// move across adds a push and a pop whose sift-down walks one level at a
// time, reading the left and the right child and then comparing. A refused
// item is answered from idle without walking either heap.
// Reset clears counts and median; heap memories need no clearing.
// A stalled result holds and blocks the next item.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top import rmth_pkg::*; #(
  parameter int unsigned HeapDepth = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [MedianW-1:0]      median_doubled_o,
  output logic                    full_error_o,
  output logic [CountW-1:0]       sample_count_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [ValueW-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) value_q <= value_i;
  end

  rmth_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd), .full_error_o
  );

  rmth_datapath #(.HeapDepth(HeapDepth)) u_dp (
    .clk_i, .rst_ni, .value_i(in_stall_o ? value_q : value_i), .cmd_i(cmd),
    .status_o(status), .median_o(median_doubled_o), .count_o(sample_count_o)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.busy |-> in_stall_o) else $error("item taken mid walk");
  a_err_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && full_error_o && !$past(out_valid_o)) |-> $stable(sample_count_o))
    else $error("refused item changed count");
`endif

endmodule : running_median_two_heaps_top
`default_nettype wire

// ===== rtl/core/rmth_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running median datapath
// Two heap memories, counts, a sift-up and sift-down walker and the median.
// ----------------------------------------------------------------------------
module rmth_datapath import rmth_pkg::*; #(
  parameter int unsigned HeapDepth = 512
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ValueW-1:0]  value_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_status_t              status_o,
  output logic [MedianW-1:0]      median_o,
  output logic [CountW-1:0]       count_o
);

  localparam int unsigned AddrW = (HeapDepth > 1) ? $clog2(HeapDepth) : 1;
  localparam int unsigned CntW  = $clog2(HeapDepth + 1);

  logic [ValueW-1:0] lo_mem [HeapDepth];
  logic [ValueW-1:0] up_mem [HeapDepth];

  logic [CntW-1:0]    lo_cnt_q, up_cnt_q;
  logic [MedianW-1:0] med_q;
  logic [ValueW-1:0]  lo_top_q, up_top_q;  // copies of entry 0 of each heap

  // walker state
  typedef enum logic [2:0] {
    W_IDLE, W_UP_RD, W_UP_CMP, W_DN_RD, W_DN_RD2, W_DN_CMP
  } walk_e;
  walk_e             ws_q;
  logic              sel_q;
  logic [ValueW-1:0] key_q;     // value being placed
  logic [CntW-1:0]   idx_q;     // hole position
  logic [CntW-1:0]   lim_q;     // heap size during the walk
  logic [CntW-1:0]   cidx_q;    // left child of the hole
  logic [ValueW-1:0] rd_q;      // left child value

  // one read port and one write port per memory, muxed by selection
  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [ValueW-1:0] wdata, rdat_lo, rdat_up;

  always_ff @(posedge clk_i) begin
    if (we && !sel_q) lo_mem[waddr] <= wdata;
    if (we &&  sel_q) up_mem[waddr] <= wdata;
    rdat_lo <= lo_mem[raddr];
    rdat_up <= up_mem[raddr];
  end

  wire [ValueW-1:0] rdat = sel_q ? rdat_up : rdat_lo;

  function automatic logic goes_first(input logic [ValueW-1:0] x,
                                      input logic [ValueW-1:0] y,
                                      input logic is_min);
    goes_first = is_min ? (x < y) : (x > y);
  endfunction

  logic [CntW-1:0] parent, child1;
  assign parent = (idx_q - CntW'(1)) >> 1;
  assign child1 = {idx_q[CntW-2:0], 1'b1};

  logic [ValueW:0] v2;
  assign v2 = {value_i, 1'b0};

  // right child arrives in the compare state; pick the better child
  logic              dn_right, dn_sink;
  logic [ValueW-1:0] dn_best;
  logic [CntW-1:0]   dn_idx;
  assign dn_right = (cidx_q + CntW'(1) < lim_q) && goes_first(rdat, rd_q, sel_q);
  assign dn_best  = dn_right ? rdat : rd_q;
  assign dn_idx   = dn_right ? cidx_q + CntW'(1) : cidx_q;
  assign dn_sink  = (cidx_q < lim_q) && goes_first(dn_best, key_q, sel_q);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AddrW-1:0];
    wdata = key_q;
    raddr = parent[AddrW-1:0];
    case (ws_q)
      W_UP_RD:  raddr = parent[AddrW-1:0];
      W_UP_CMP: begin
        if (idx_q != '0 && goes_first(key_q, rdat, sel_q)) begin
          we = 1'b1; wdata = rdat;
        end else begin
          we = 1'b1;
        end
      end
      W_DN_RD:  raddr = child1[AddrW-1:0];
      W_DN_RD2: raddr = AddrW'(child1 + CntW'(1));
      W_DN_CMP: begin
        we = 1'b1;
        if (dn_sink) wdata = dn_best;
      end
      default: ;
    endcase
    if (ws_q == W_IDLE && cmd_i.op == OP_POP_START)
      raddr = AddrW'((cmd_i.heap_sel ? up_cnt_q : lo_cnt_q) - CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q     <= W_IDLE;
      lo_cnt_q <= '0;
      up_cnt_q <= '0;
      med_q    <= '0;
      sel_q    <= 1'b0;
    end else begin
      case (ws_q)
        W_IDLE: begin
          case (cmd_i.op)
            OP_PUSH_START: begin
              sel_q <= cmd_i.heap_sel;
              key_q <= cmd_i.src_top ? (cmd_i.heap_sel ? lo_top_q : up_top_q) : value_i;
              idx_q <= cmd_i.heap_sel ? up_cnt_q : lo_cnt_q;
              if (cmd_i.heap_sel) up_cnt_q <= up_cnt_q + CntW'(1);
              else                lo_cnt_q <= lo_cnt_q + CntW'(1);
              ws_q <= W_UP_RD;
            end
            OP_POP_START: begin
              sel_q <= cmd_i.heap_sel;
              idx_q <= '0;
              lim_q <= (cmd_i.heap_sel ? up_cnt_q : lo_cnt_q) - CntW'(1);
              if (cmd_i.heap_sel) up_cnt_q <= up_cnt_q - CntW'(1);
              else                lo_cnt_q <= lo_cnt_q - CntW'(1);
              ws_q <= W_DN_RD2;  // fetch last entry first (read issued now)
              cidx_q <= '1;      // marks the initial fetch
            end
            OP_MEDIAN: begin
              if (cmd_i.med_two)
                med_q <= {(cmd_i.heap_sel ? up_top_q : lo_top_q), 1'b0};
              else
                med_q <= MedianW'(lo_top_q) + MedianW'(up_top_q);
            end
            default: begin
              if (lo_cnt_q == '0 && cmd_i.op == OP_PUSH_STEP) med_q <= v2;
            end
          endcase
        end
        W_UP_RD: ws_q <= W_UP_CMP;
        W_UP_CMP: begin
          if (idx_q != '0 && goes_first(key_q, rdat, sel_q)) begin
            if (idx_q == CntW'(1) || idx_q == CntW'(2)) begin
              if (sel_q) up_top_q <= rdat; else lo_top_q <= rdat;
            end
            idx_q <= parent;
            ws_q  <= W_UP_RD;
          end else begin
            if (idx_q == '0) begin
              if (sel_q) up_top_q <= key_q; else lo_top_q <= key_q;
            end
            ws_q <= W_IDLE;
          end
        end
        W_DN_RD: ws_q <= W_DN_RD2;
        W_DN_RD2: begin
          if (cidx_q == '1) begin
            // last entry arrives now; start the walk unless heap became empty
            cidx_q <= '0;
            if (lim_q == '0) ws_q <= W_IDLE;
            else begin
              key_q <= rdat;
              ws_q  <= W_DN_RD;
            end
          end else begin
            rd_q   <= rdat;   // left child
            cidx_q <= child1;
            ws_q   <= W_DN_CMP;
          end
        end
        W_DN_CMP: begin
          if (idx_q == '0) begin
            if (sel_q) up_top_q <= dn_sink ? dn_best : key_q;
            else       lo_top_q <= dn_sink ? dn_best : key_q;
          end
          if (dn_sink) begin
            idx_q <= dn_idx;
            ws_q  <= W_DN_RD;
          end else begin
            ws_q <= W_IDLE;
          end
        end
        default: ws_q <= W_IDLE;
      endcase
    end
  end

  always_comb begin
    status_o.busy        = (ws_q != W_IDLE);
    status_o.lower_empty = (lo_cnt_q == '0);
    status_o.v2_eq       = (v2 == med_q);
    status_o.v2_lt       = (MedianW'(v2) < med_q);
    status_o.lower_le    = (lo_cnt_q <= up_cnt_q);
    status_o.same        = (lo_cnt_q == up_cnt_q);
    status_o.lower_full  = (lo_cnt_q >= CntW'(HeapDepth));
    status_o.upper_full  = (up_cnt_q >= CntW'(HeapDepth));
  end

  assign median_o = med_q;
  assign count_o  = CountW'({1'b0, lo_cnt_q} + {1'b0, up_cnt_q});

endmodule : rmth_datapath
`default_nettype wire

// ===== rtl/core/rmth_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Running median controller
// Decides the insertion case and sequences push, pop and median updates.
// ----------------------------------------------------------------------------
module rmth_ctrl import rmth_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            full_error_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE, S_POP, S_PUSH, S_WAIT, S_MED
  } state_e;

  state_e state_q;
  logic   own_q, med_two_q, move_q, err_q, phase_q;

  // state to command; S_WAIT waits out the walk, phase_q flags the first wait after each command
  always_comb begin
    cmd_o = '{op: OP_NONE, heap_sel: own_q, src_top: 1'b0, med_two: med_two_q};
    case (state_q)
      S_MOVE: begin cmd_o.op = OP_PUSH_START; cmd_o.heap_sel = !own_q; cmd_o.src_top = 1'b1; end
      S_POP:  cmd_o.op = OP_POP_START;
      S_PUSH: cmd_o.op = OP_PUSH_START;
      S_MED:  cmd_o.op = OP_MEDIAN;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_o && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      full_error_o<= 1'b0;
      own_q <= 1'b0; med_two_q <= 1'b0; move_q <= 1'b0; err_q <= 1'b0; phase_q <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && !in_stall_o) begin
          move_q <= 1'b0;
          if (status_i.lower_empty) begin
            own_q <= 1'b0; med_two_q <= 1'b1; state_q <= S_PUSH;
          end else if (status_i.v2_eq) begin
            own_q     <= !status_i.lower_le;
            med_two_q <= status_i.same;
            if (status_i.lower_le ? status_i.lower_full : status_i.upper_full) begin
              full_error_o <= 1'b1; out_valid_o <= 1'b1;
            end else state_q <= S_PUSH;
          end else begin
            // own side: lower if below median
            own_q <= !status_i.v2_lt;
            med_two_q <= status_i.same;
            if (status_i.same) begin
              if (status_i.v2_lt ? status_i.lower_full : status_i.upper_full) begin
                full_error_o <= 1'b1; out_valid_o <= 1'b1;
              end else state_q <= S_PUSH;
            end else if (status_i.v2_lt == status_i.lower_le) begin
              state_q <= S_PUSH;  // own side smaller, cannot be full
            end else begin
              if (status_i.v2_lt ? status_i.upper_full : status_i.lower_full) begin
                full_error_o <= 1'b1; out_valid_o <= 1'b1;
              end else begin
                move_q <= 1'b1; state_q <= S_MOVE;
              end
            end
          end
        end
        S_MOVE: state_q <= S_WAIT;
        S_POP:  state_q <= S_WAIT;
        S_PUSH: begin state_q <= S_WAIT; move_q <= 1'b0; err_q <= 1'b1; end
        S_WAIT: if (!status_i.busy && !phase_q) begin
          if (move_q && !err_q) begin
            state_q <= S_POP; err_q <= 1'b1;
          end else if (move_q) begin
            state_q <= S_PUSH;
          end else begin
            state_q <= S_MED;
          end
        end
        S_MED: begin
          err_q        <= 1'b0;
          full_error_o <= 1'b0;
          out_valid_o  <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      phase_q <= (state_q == S_MOVE) || (state_q == S_POP) || (state_q == S_PUSH);
      if (state_q == S_IDLE && in_valid_i && !in_stall_o) err_q <= 1'b0;
    end
  end

endmodule : rmth_ctrl
`default_nettype wire
